/* rtl/bbc_pkg.sv */
// Shared constants, types and helper functions of the bracket balance checker.
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

   localparam int unsigned StackDepthDefault = 256;

   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_LPAREN    = 8'h28;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_NONE      = 8'h00;

   typedef enum logic [1:0] {
      BR_CURLY  = 2'd0,
      BR_ROUND  = 2'd1,
      BR_SQUARE = 2'd2
   } bracket_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_MISMATCH    = 3'd1,
      ST_EMPTY_CLOSE = 3'd2,
      ST_NL_IN_QUOTE = 3'd3,
      ST_QUOTE_OPEN  = 3'd4,
      ST_SCOPE_OPEN  = 3'd5,
      ST_TOO_DEEP    = 3'd6
   } status_type;

   typedef struct packed {
      logic        push;
      logic        pop;
      logic        clear;
      bracket_type code;
   } stack_cmd_type;

   function automatic logic [7:0] open_char_of(bracket_type kind);
      logic [7:0] result;
      case (kind)
         BR_CURLY:  result = CHAR_LBRACE;
         BR_ROUND:  result = CHAR_LPAREN;
         BR_SQUARE: result = CHAR_LBRACKET;
         default:   result = CHAR_NONE;
      endcase
      return result;
   endfunction

   function automatic logic [7:0] quote_char_of(logic single_kind);
      return single_kind ? CHAR_SQUOTE : CHAR_DQUOTE;
   endfunction

endpackage

`default_nettype wire

/* rtl/bbc_if.sv */
// Valid/ready channel interfaces for text bytes in and check results out.
`timescale 1ns / 1ps
`default_nettype none

interface bbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface bbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] found_char;
   logic [7:0] open_char;
   logic [8:0] depth;

   modport source (output valid, output status, output found_char, output open_char,
                   output depth, input ready);
   modport sink   (input valid, input status, input found_char, input open_char,
                   input depth, output ready);
endinterface

`default_nettype wire

/* rtl/bbc_stack.sv */
// Bracket stack: memory of open bracket codes with registered top and prefetched next entry.
`timescale 1ns / 1ps
`default_nettype none

module bbc_stack #(
   parameter int unsigned STACK_DEPTH = bbc_pkg::StackDepthDefault
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  bbc_pkg::stack_cmd_type                cmd,
   output logic [$clog2(STACK_DEPTH + 1) - 1:0] depth,
   output bbc_pkg::bracket_type                  top,
   output bbc_pkg::bracket_type                  below
);

   localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int unsigned AW    = $clog2(STACK_DEPTH);

   bbc_pkg::bracket_type stack_mem [STACK_DEPTH];

   logic [CNT_W-1:0]     depth_ff;
   logic [CNT_W-1:0]     depth_in;
   bbc_pkg::bracket_type top_ff;
   bbc_pkg::bracket_type top_in;
   bbc_pkg::bracket_type below_ff;
   logic [CNT_W-1:0]     rd_idx;

   always_comb begin
      if (cmd.clear) begin
         depth_in = '0;
      end else if (cmd.push) begin
         depth_in = depth_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         depth_in = depth_ff - CNT_W'(1);
      end else begin
         depth_in = depth_ff;
      end

      if (cmd.push) begin
         top_in = cmd.code;
      end else if (cmd.pop) begin
         top_in = below_ff;
      end else begin
         top_in = top_ff;
      end
   end

   // The entry under the new top is fetched every cycle, so it is ready for a pop in the
   // next one. A push writes one entry above that address, so the two never collide.
   assign rd_idx = depth_in - CNT_W'(2);

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[depth_ff[AW-1:0]] <= cmd.code;
      end
      below_ff <= stack_mem[rd_idx[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
      top_ff <= top_in;
   end

   assign depth = depth_ff;
   assign top   = top_ff;
   assign below = below_ff;

endmodule

`default_nettype wire

/* rtl/bbc_scan.sv */
// Text scanner: comment and quote tracking, stack commands, error latch and result fields.
`timescale 1ns / 1ps
`default_nettype none

module bbc_scan #(
   parameter int unsigned STACK_DEPTH = bbc_pkg::StackDepthDefault
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   fire,
   input  wire  [7:0]                            text_byte,
   input  wire                                   end_of_text,
   input  wire  [$clog2(STACK_DEPTH + 1) - 1:0] depth,
   input  bbc_pkg::bracket_type                  top,
   input  bbc_pkg::bracket_type                  below,
   output bbc_pkg::stack_cmd_type                cmd,
   output bbc_pkg::status_type                   status,
   output logic [7:0]                            found_char,
   output logic [7:0]                            open_char,
   output logic [8:0]                            depth_out,
   output bbc_pkg::status_type                   err_code
);

   localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

   logic                in_quote_ff,   in_quote_in;
   logic                quote_kind_ff, quote_kind_in;
   logic                in_comment_ff, in_comment_in;
   logic [7:0]          prev_ff,       prev_in;
   bbc_pkg::status_type err_ff,        err_in;
   logic [7:0]          err_found_ff,  err_found_in;
   logic [7:0]          err_open_ff,   err_open_in;

   bbc_pkg::stack_cmd_type cmd_raw;
   logic                   raise;
   bbc_pkg::status_type    raise_code;
   logic                   is_open, is_close, is_quote, is_nl, prev_esc;
   bbc_pkg::bracket_type   open_code, close_code;
   logic [7:0]             innermost_now, innermost_next;
   logic [CNT_W-1:0]       depth_next;
   bbc_pkg::bracket_type   top_next;
   logic [CNT_W+8:0]       depth_wide;

   always_comb begin
      is_open    = 1'b0;
      is_close   = 1'b0;
      open_code  = bbc_pkg::BR_CURLY;
      close_code = bbc_pkg::BR_CURLY;
      case (text_byte)
         bbc_pkg::CHAR_LBRACE: begin
            is_open   = 1'b1;
            open_code = bbc_pkg::BR_CURLY;
         end
         bbc_pkg::CHAR_LPAREN: begin
            is_open   = 1'b1;
            open_code = bbc_pkg::BR_ROUND;
         end
         bbc_pkg::CHAR_LBRACKET: begin
            is_open   = 1'b1;
            open_code = bbc_pkg::BR_SQUARE;
         end
         bbc_pkg::CHAR_RBRACE: begin
            is_close   = 1'b1;
            close_code = bbc_pkg::BR_CURLY;
         end
         bbc_pkg::CHAR_RPAREN: begin
            is_close   = 1'b1;
            close_code = bbc_pkg::BR_ROUND;
         end
         bbc_pkg::CHAR_RBRACKET: begin
            is_close   = 1'b1;
            close_code = bbc_pkg::BR_SQUARE;
         end
         default: begin
            is_open  = 1'b0;
            is_close = 1'b0;
         end
      endcase
   end

   assign is_quote = (text_byte == bbc_pkg::CHAR_DQUOTE) || (text_byte == bbc_pkg::CHAR_SQUOTE);
   assign is_nl    = (text_byte == bbc_pkg::CHAR_NEWLINE);
   assign prev_esc = (prev_ff == bbc_pkg::CHAR_BACKSLASH);

   assign innermost_now = in_quote_ff ? bbc_pkg::quote_char_of(quote_kind_ff) :
                          (depth != '0) ? bbc_pkg::open_char_of(top) : bbc_pkg::CHAR_NONE;

   always_comb begin
      in_quote_in   = in_quote_ff;
      quote_kind_in = quote_kind_ff;
      in_comment_in = in_comment_ff;
      prev_in       = text_byte;
      cmd_raw       = '0;
      raise         = 1'b0;
      raise_code    = bbc_pkg::ST_OK;

      if (in_comment_ff && is_nl) begin
         in_comment_in = 1'b0;
      end else if (text_byte == bbc_pkg::CHAR_SLASH && prev_ff == bbc_pkg::CHAR_SLASH &&
                   !in_quote_ff) begin
         in_comment_in = 1'b1;
      end else if (is_quote && !prev_esc && !in_comment_ff) begin
         if (!in_quote_ff) begin
            in_quote_in   = 1'b1;
            quote_kind_in = (text_byte == bbc_pkg::CHAR_SQUOTE);
         end else if (quote_kind_ff == (text_byte == bbc_pkg::CHAR_SQUOTE)) begin
            in_quote_in = 1'b0;
         end
      end else if (in_quote_ff && is_nl && !prev_esc) begin
         raise      = 1'b1;
         raise_code = bbc_pkg::ST_NL_IN_QUOTE;
      end else if (!in_comment_ff && !in_quote_ff) begin
         if (is_open) begin
            if (depth >= CNT_W'(STACK_DEPTH)) begin
               raise      = 1'b1;
               raise_code = bbc_pkg::ST_TOO_DEEP;
            end else begin
               cmd_raw.push = 1'b1;
               cmd_raw.code = open_code;
            end
         end else if (is_close) begin
            if (depth == '0) begin
               raise      = 1'b1;
               raise_code = bbc_pkg::ST_EMPTY_CLOSE;
            end else begin
               // A mismatched closer still removes the top entry.
               if (top != close_code) begin
                  raise      = 1'b1;
                  raise_code = bbc_pkg::ST_MISMATCH;
               end
               cmd_raw.pop = 1'b1;
            end
         end
      end

      err_in       = err_ff;
      err_found_in = err_found_ff;
      err_open_in  = err_open_ff;
      if (raise && err_ff == bbc_pkg::ST_OK) begin
         err_in       = raise_code;
         err_found_in = text_byte;
         err_open_in  = innermost_now;
      end

      if (end_of_text) begin
         in_quote_in   = 1'b0;
         quote_kind_in = 1'b0;
         in_comment_in = 1'b0;
         prev_in       = '0;
         err_in        = bbc_pkg::ST_OK;
         err_found_in  = '0;
         err_open_in   = '0;
         cmd_raw       = '0;
         cmd_raw.clear = 1'b1;
      end
   end

   always_comb begin
      if (cmd_raw.push) begin
         depth_next = depth + CNT_W'(1);
         top_next   = cmd_raw.code;
      end else if (cmd_raw.pop) begin
         depth_next = depth - CNT_W'(1);
         top_next   = below;
      end else begin
         depth_next = depth;
         top_next   = top;
      end
   end

   assign innermost_next = in_quote_in ? bbc_pkg::quote_char_of(quote_kind_in) :
                           (depth_next != '0) ? bbc_pkg::open_char_of(top_next) :
                           bbc_pkg::CHAR_NONE;

   always_comb begin
      if (end_of_text) begin
         depth_wide = (CNT_W + 9)'(depth);
         if (err_ff != bbc_pkg::ST_OK) begin
            status     = err_ff;
            found_char = err_found_ff;
            open_char  = err_open_ff;
         end else begin
            found_char = bbc_pkg::CHAR_NONE;
            open_char  = innermost_now;
            if (in_quote_ff) begin
               status = bbc_pkg::ST_QUOTE_OPEN;
            end else if (depth != '0) begin
               status = bbc_pkg::ST_SCOPE_OPEN;
            end else begin
               status = bbc_pkg::ST_OK;
            end
         end
      end else begin
         depth_wide = (CNT_W + 9)'(depth_next);
         status     = err_in;
         if (err_in != bbc_pkg::ST_OK) begin
            found_char = err_found_in;
            open_char  = err_open_in;
         end else begin
            found_char = bbc_pkg::CHAR_NONE;
            open_char  = innermost_next;
         end
      end
   end

   assign depth_out = depth_wide[8:0];
   assign cmd       = fire ? cmd_raw : '0;
   assign err_code  = err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quote_ff   <= 1'b0;
         quote_kind_ff <= 1'b0;
         in_comment_ff <= 1'b0;
         prev_ff       <= '0;
         err_ff        <= bbc_pkg::ST_OK;
         err_found_ff  <= '0;
         err_open_ff   <= '0;
      end else if (fire) begin
         in_quote_ff   <= in_quote_in;
         quote_kind_ff <= quote_kind_in;
         in_comment_ff <= in_comment_in;
         prev_ff       <= prev_in;
         err_ff        <= err_in;
         err_found_ff  <= err_found_in;
         err_open_ff   <= err_open_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/bracket_balance_checker_core.sv */
// Bracket balance checker: one result per text byte, through an output register.
// A result is registered and presented on rsp in the cycle after its byte transfers on req.
// Throughput: one byte per cycle unless rsp back-pressures; the stack memory reads the entry below
// the new top every cycle, so push, pop and compare never hold off the input.
// Reset: synchronous; clears depth, quote, comment and error state; no memory clearing pass.
// An end-of-text transfer returns the verdict and clears the same state.
`timescale 1ns / 1ps
`default_nettype none

module bracket_balance_checker_core #(
   parameter int unsigned STACK_DEPTH = bbc_pkg::StackDepthDefault
) (
   input wire     clock,
   input wire     reset,
   bbc_req_if.sink   req,
   bbc_rsp_if.source rsp
);

   localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

   logic                   fire;
   bbc_pkg::stack_cmd_type cmd;
   logic [CNT_W-1:0]       depth;
   bbc_pkg::bracket_type   top;
   bbc_pkg::bracket_type   below;
   bbc_pkg::status_type    status;
   logic [7:0]             found_char;
   logic [7:0]             open_char;
   logic [8:0]             depth_out;
   bbc_pkg::status_type    err_code;

   logic                rsp_valid_ff;
   bbc_pkg::status_type rsp_status_ff;
   logic [7:0]          rsp_found_ff;
   logic [7:0]          rsp_open_ff;
   logic [8:0]          rsp_depth_ff;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign fire      = req.valid && req.ready;

   bbc_stack #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock(clock),
      .reset(reset),
      .cmd  (cmd),
      .depth(depth),
      .top  (top),
      .below(below)
   );

   bbc_scan #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .text_byte  (req.text_byte),
      .end_of_text(req.end_of_text),
      .depth      (depth),
      .top        (top),
      .below      (below),
      .cmd        (cmd),
      .status     (status),
      .found_char (found_char),
      .open_char  (open_char),
      .depth_out  (depth_out),
      .err_code   (err_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire) begin
         rsp_status_ff <= status;
         rsp_found_ff  <= found_char;
         rsp_open_ff   <= open_char;
         rsp_depth_ff  <= depth_out;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.found_char = rsp_found_ff;
   assign rsp.open_char  = rsp_open_ff;
   assign rsp.depth      = rsp_depth_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth <= CNT_W'(STACK_DEPTH))
      else $error("bracket stack count beyond its capacity");

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      fire && req.end_of_text |=> depth == '0 && err_code == bbc_pkg::ST_OK)
      else $error("end-of-text transfer did not clear the checker state");

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      err_code != bbc_pkg::ST_OK && !(fire && req.end_of_text) |=> err_code == $past(err_code))
      else $error("latched error changed before end of text");

   a_push_top: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> top == $past(cmd.code) && depth == $past(depth) + CNT_W'(1))
      else $error("pushed bracket is not on top of the stack");

endmodule

`default_nettype wire

/* test/bracket_balance_checker_core_tb.sv */
// Self-checking testbench for the bracket balance checker core, with a predicting scoreboard.
`timescale 1ns / 1ps

import bbc_pkg::*;

module bracket_balance_checker_core_tb;

   localparam int unsigned NEST_LIMIT    = StackDepthDefault;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned LONG_HOLD     = 120;
   localparam int unsigned PHASE_ITEMS   = 280;
   localparam int unsigned SETTLE_CYCLES = 4;

   localparam logic [7:0] OPENERS [3] = '{CHAR_LBRACE, CHAR_LPAREN, CHAR_LBRACKET};
   localparam logic [7:0] CLOSERS [3] = '{CHAR_RBRACE, CHAR_RPAREN, CHAR_RBRACKET};

   typedef struct packed {
      status_type status;
      logic [7:0] found_char;
      logic [7:0] open_char;
      logic [8:0] depth;
   } check_result_type;

   // Tracks the text seen so far and holds the results still owed by the block.
   class bracket_scoreboard;
      bracket_type  nest [NEST_LIMIT];
      int unsigned  nest_count;
      bit           in_quote;
      bit           single_quote;
      bit           in_comment;
      logic [7:0]   last_byte;
      status_type   first_error;
      logic [7:0]   error_found;
      logic [7:0]   error_open;
      check_result_type pending [$];
      int unsigned  failures;
      int unsigned  results_checked;
      int unsigned  verdicts;
      int unsigned  verdict_kinds [8];

      function new();
         clear_state();
      endfunction

      function void clear_state();
         nest_count   = 0;
         in_quote     = 1'b0;
         single_quote = 1'b0;
         in_comment   = 1'b0;
         last_byte    = CHAR_NONE;
         first_error  = ST_OK;
         error_found  = CHAR_NONE;
         error_open   = CHAR_NONE;
      endfunction

      function logic [7:0] innermost();
         logic [7:0] ch;
         ch = CHAR_NONE;
         if (in_quote) begin
            ch = single_quote ? CHAR_SQUOTE : CHAR_DQUOTE;
         end else if (nest_count > 0) begin
            case (nest[nest_count - 1])
               BR_CURLY:  ch = CHAR_LBRACE;
               BR_ROUND:  ch = CHAR_LPAREN;
               BR_SQUARE: ch = CHAR_LBRACKET;
               default:   ch = CHAR_NONE;
            endcase
         end
         return ch;
      endfunction

      // Only the first error is kept; later ones leave the latch alone.
      function void flag(status_type code, logic [7:0] ch);
         if (first_error == ST_OK) begin
            first_error = code;
            error_found = ch;
            error_open  = innermost();
         end
      endfunction

      function void note_input(logic [7:0] ch, logic eot);
         check_result_type want;
         bracket_type      kind;
         bit               opens_scope;
         bit               closes_scope;
         bit               is_single;
         want = '0;
         if (eot) begin
            want.status = first_error;
            if (first_error != ST_OK) begin
               want.found_char = error_found;
               want.open_char  = error_open;
            end else if (in_quote) begin
               want.status    = ST_QUOTE_OPEN;
               want.open_char = innermost();
            end else if (nest_count > 0) begin
               want.status    = ST_SCOPE_OPEN;
               want.open_char = innermost();
            end
            want.depth = nest_count[8:0];
            verdicts++;
            verdict_kinds[want.status]++;
            clear_state();
         end else begin
            kind         = BR_CURLY;
            opens_scope  = 1'b0;
            closes_scope = 1'b0;
            case (ch)
               CHAR_LBRACE:   begin opens_scope  = 1'b1; kind = BR_CURLY;  end
               CHAR_LPAREN:   begin opens_scope  = 1'b1; kind = BR_ROUND;  end
               CHAR_LBRACKET: begin opens_scope  = 1'b1; kind = BR_SQUARE; end
               CHAR_RBRACE:   begin closes_scope = 1'b1; kind = BR_CURLY;  end
               CHAR_RPAREN:   begin closes_scope = 1'b1; kind = BR_ROUND;  end
               CHAR_RBRACKET: begin closes_scope = 1'b1; kind = BR_SQUARE; end
               default: ;
            endcase
            if (in_comment && ch == CHAR_NEWLINE) begin
               in_comment = 1'b0;
            end else if (ch == CHAR_SLASH && last_byte == CHAR_SLASH && !in_quote) begin
               in_comment = 1'b1;
            end else if ((ch == CHAR_DQUOTE || ch == CHAR_SQUOTE) &&
                         last_byte != CHAR_BACKSLASH && !in_comment) begin
               is_single = (ch == CHAR_SQUOTE);
               if (!in_quote) begin
                  in_quote     = 1'b1;
                  single_quote = is_single;
               end else if (single_quote == is_single) begin
                  in_quote = 1'b0;
               end
            end else if (in_quote && ch == CHAR_NEWLINE && last_byte != CHAR_BACKSLASH) begin
               flag(ST_NL_IN_QUOTE, ch);
            end else if (!in_comment && !in_quote) begin
               if (opens_scope) begin
                  if (nest_count >= NEST_LIMIT) begin
                     flag(ST_TOO_DEEP, ch);
                  end else begin
                     nest[nest_count] = kind;
                     nest_count++;
                  end
               end else if (closes_scope) begin
                  if (nest_count == 0) begin
                     flag(ST_EMPTY_CLOSE, ch);
                  end else begin
                     // A wrong closer still removes the top entry.
                     if (nest[nest_count - 1] != kind) flag(ST_MISMATCH, ch);
                     nest_count--;
                  end
               end
            end
            last_byte   = ch;
            want.status = first_error;
            if (first_error != ST_OK) begin
               want.found_char = error_found;
               want.open_char  = error_open;
            end else begin
               want.open_char = innermost();
            end
            want.depth = nest_count[8:0];
         end
         pending.push_back(want);
      endfunction

      function void check_result(check_result_type got);
         check_result_type want;
         if (pending.size() == 0) begin
            $error("result arrived with none outstanding: status %0d depth %0d",
                   got.status, got.depth);
            failures++;
            return;
         end
         want = pending.pop_front();
         results_checked++;
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         if (got.found_char !== want.found_char) begin
            $error("found_char: expected %02h, got %02h", want.found_char, got.found_char);
            failures++;
         end
         if (got.open_char !== want.open_char) begin
            $error("open_char: expected %02h, got %02h", want.open_char, got.open_char);
            failures++;
         end
         if (got.depth !== want.depth) begin
            $error("depth: expected %0d, got %0d", want.depth, got.depth);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   bbc_req_if req ();
   bbc_rsp_if rsp ();

   bracket_balance_checker_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   bracket_scoreboard sb = new();

   int unsigned cycle_count;
   int unsigned items_sent;
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned holds_asked;
   int unsigned holds_done;
   int unsigned hold_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycle_count = 0;
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timed out after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
   end

   // Result side: checks each transfer and decides ready for the next edge.
   initial begin
      rsp.ready <= 1'b0;
      hold_left = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready) begin
            sb.check_result('{status_type'(rsp.status), rsp.found_char, rsp.open_char,
                              rsp.depth});
         end
         if (holds_done < holds_asked) begin
            hold_left = LONG_HOLD;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic send_item(input logic [7:0] ch, input logic eot);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.text_byte   <= ch;
      req.end_of_text <= eot;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_input(ch, eot);
      items_sent++;
   endtask

   task automatic send_end();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_string(input string text);
      for (int i = 0; i < text.len(); i++) send_item(text[i], 1'b0);
      send_end();
   endtask

   task automatic send_quoted();
      logic [7:0] quote_ch;
      int         body;
      quote_ch = $urandom_range(0, 1) ? CHAR_SQUOTE : CHAR_DQUOTE;
      send_item(quote_ch, 1'b0);
      body = $urandom_range(0, 6);
      repeat (body) begin
         case ($urandom_range(0, 9))
            0: begin send_item(CHAR_BACKSLASH, 1'b0); send_item(quote_ch, 1'b0); end
            1: send_item(quote_ch == CHAR_SQUOTE ? CHAR_DQUOTE : CHAR_SQUOTE, 1'b0);
            2: send_item($urandom_range(0, 1) ? OPENERS[$urandom_range(0, 2)]
                                              : CLOSERS[$urandom_range(0, 2)], 1'b0);
            3: send_item($urandom_range(0, 4) == 0 ? CHAR_NEWLINE : 8'h61, 1'b0);
            4: begin send_item(CHAR_BACKSLASH, 1'b0); send_item(CHAR_NEWLINE, 1'b0); end
            5: send_item(CHAR_SLASH, 1'b0);
            default: send_item(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
         endcase
      end
      if ($urandom_range(0, 9) != 0) send_item(quote_ch, 1'b0);
   endtask

   task automatic send_comment();
      int body;
      send_item(CHAR_SLASH, 1'b0);
      send_item(CHAR_SLASH, 1'b0);
      body = $urandom_range(0, 6);
      repeat (body) begin
         case ($urandom_range(0, 3))
            0: send_item(OPENERS[$urandom_range(0, 2)], 1'b0);
            1: send_item(CLOSERS[$urandom_range(0, 2)], 1'b0);
            2: send_item($urandom_range(0, 1) ? CHAR_SQUOTE : CHAR_DQUOTE, 1'b0);
            default: send_item(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
         endcase
      end
      send_item(CHAR_NEWLINE, 1'b0);
   endtask

   // Mostly well-nested text with strings and comments, plus some stray bytes.
   task automatic send_random_text();
      int    open_kinds [$];
      int    pieces;
      int    roll;
      int    k;
      string plain;
      plain = "ab =;1x\t";
      pieces = $urandom_range(0, 24);
      repeat (pieces) begin
         roll = $urandom_range(0, 99);
         if (roll < 25) begin
            k = $urandom_range(0, 2);
            open_kinds.push_back(k);
            send_item(OPENERS[k], 1'b0);
         end else if (roll < 45) begin
            if (open_kinds.size() > 0) k = open_kinds.pop_back();
            else k = $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) k = $urandom_range(0, 2);
            send_item(CLOSERS[k], 1'b0);
         end else if (roll < 55) begin
            send_quoted();
         end else if (roll < 62) begin
            send_comment();
         end else if (roll < 85) begin
            send_item(plain[$urandom_range(0, plain.len() - 1)], 1'b0);
         end else begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
         end
      end
      if ($urandom_range(0, 9) < 8) begin
         while (open_kinds.size() > 0) send_item(CLOSERS[open_kinds.pop_back()], 1'b0);
      end
      send_end();
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall);
      int unsigned phase_end;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      phase_end     = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_random_text();
   endtask

   initial begin
      req.valid       <= 1'b0;
      req.text_byte   <= CHAR_NONE;
      req.end_of_text <= 1'b0;
      reset           <= 1'b1;
      items_sent    = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      holds_asked   = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_string("([{}])");
      send_string("}(]");
      send_string("\"'\n");
      send_string(string'({"'", 8'hFF}));
      send_string("\\\"[");
      send_string("//)\n");
      send_item(CHAR_NONE, 1'b0);
      send_end();

      // Overflow the nesting store while the result side holds off, so the block backs up.
      holds_asked = 1;
      repeat (NEST_LIMIT) send_item(CHAR_LBRACE, 1'b0);
      send_item(CHAR_LPAREN, 1'b0);
      send_item(CHAR_RBRACKET, 1'b0);
      send_end();

      run_phase(0, 0);
      run_phase(83, 0);
      run_phase(0, 83);
      run_phase(9, 9);

      req.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d items in %0d texts; %0d results checked.",
               items_sent, sb.verdicts, sb.results_checked);
      $write("Verdicts: ok %0d, mismatch %0d, empty close %0d, newline in quote %0d, ",
             sb.verdict_kinds[ST_OK], sb.verdict_kinds[ST_MISMATCH],
             sb.verdict_kinds[ST_EMPTY_CLOSE], sb.verdict_kinds[ST_NL_IN_QUOTE]);
      $display("quote open %0d, scopes open %0d, too deep %0d.",
               sb.verdict_kinds[ST_QUOTE_OPEN], sb.verdict_kinds[ST_SCOPE_OPEN],
               sb.verdict_kinds[ST_TOO_DEEP]);
      if (sb.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* bracket_balance_checker_core.f */
rtl/bbc_pkg.sv
rtl/bbc_if.sv
rtl/bbc_stack.sv
rtl/bbc_scan.sv
rtl/bracket_balance_checker_core.sv
test/bracket_balance_checker_core_tb.sv
